[rtl/core/lsdrs_pkg.sv]
package lsdrs_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned Radix    = 10;
  localparam int unsigned ValueW   = 31;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned DigW     = 4;
  localparam int unsigned PassW    = 4;

  typedef enum logic [2:0] {
    StLoad,
    StCount,
    StPrefix,
    StScatter,
    StCopy,
    StEmit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_store;   // write the accepted beat into the item store
    logic clear_bins;   // zero the digit bins
    logic count_step;   // count the digit of entry idx
    logic prefix_step;  // turn bin idx into a start offset
    logic scatter_step; // move entry idx into the scratch store
    logic copy_step;    // copy scratch entry idx back
    logic next_divisor; // advance to the next decimal digit
    logic reset_run;    // clear count, maximum and overflow
    logic start_sort;   // reset the divisor and the pass counter
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [PassW-1:0] passes;
    logic [PassW-1:0] pass_idx;
  } dp_sts_t;

  // Number of decimal digits of a value (zero for zero), a compare chain.
  function automatic logic [PassW-1:0] digit_total(input logic [ValueW-1:0] v);
    logic [PassW-1:0] n;
    n = '0;
    if (v >= ValueW'(1))          n = PassW'(1);
    if (v >= ValueW'(10))         n = PassW'(2);
    if (v >= ValueW'(100))        n = PassW'(3);
    if (v >= ValueW'(1000))       n = PassW'(4);
    if (v >= ValueW'(10000))      n = PassW'(5);
    if (v >= ValueW'(100000))     n = PassW'(6);
    if (v >= ValueW'(1000000))    n = PassW'(7);
    if (v >= ValueW'(10000000))   n = PassW'(8);
    if (v >= ValueW'(100000000))  n = PassW'(9);
    if (v >= ValueW'(1000000000)) n = PassW'(10);
    return n;
  endfunction

endpackage

[rtl/core/lsdrs_digit.sv]
// Splits a quotient into its lowest decimal digit and the quotient by ten.
// Each entry carries its value divided by the pass divisor, so the digit of
// the current pass is the remainder, and the stepped quotient is stored back
// for the next pass. The division by ten is a reciprocal multiply.
module lsdrs_digit (
  input  logic [lsdrs_pkg::ValueW-1:0] value_i,
  output logic [lsdrs_pkg::ValueW-1:0] quot_o,
  output logic [lsdrs_pkg::DigW-1:0]   digit_o
);
  logic [63:0] prod;
  logic [lsdrs_pkg::ValueW-1:0] q;
  logic [lsdrs_pkg::ValueW+3:0] rem;

  // floor(v / 10) = (v * 0xCCCCCCCD) >> 35 for v below 2^32.
  assign prod    = {33'd0, value_i} * 64'h0000_0000_CCCC_CCCD;
  assign q       = {2'd0, prod[63:35]};
  assign rem     = {4'd0, value_i} - ({1'b0, q, 3'd0} + {3'd0, q, 1'b0});
  assign quot_o  = q;
  assign digit_o = rem[lsdrs_pkg::DigW-1:0];
endmodule

[rtl/core/lsdrs_datapath.sv]
module lsdrs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsdrs_pkg::dp_cmd_t            cmd_i,
  input  logic [lsdrs_pkg::IdxW-1:0]    idx_i,
  input  logic [lsdrs_pkg::IdxW-1:0]    rd_idx_i,
  input  logic [lsdrs_pkg::ValueW-1:0]  in_value_i,
  output lsdrs_pkg::dp_sts_t            sts_o,
  output logic [lsdrs_pkg::ValueW-1:0]  rd_value_o,
  output logic                          overflow_o
);
  // Each entry holds the value and its remaining quotient for later digits.
  logic [lsdrs_pkg::ValueW-1:0] val_mem  [lsdrs_pkg::MaxItems];
  logic [lsdrs_pkg::ValueW-1:0] quo_mem  [lsdrs_pkg::MaxItems];
  logic [lsdrs_pkg::ValueW-1:0] sval_mem [lsdrs_pkg::MaxItems];
  logic [lsdrs_pkg::ValueW-1:0] squo_mem [lsdrs_pkg::MaxItems];

  logic [lsdrs_pkg::CntW-1:0]   bins_q [lsdrs_pkg::Radix];
  logic [lsdrs_pkg::CntW-1:0]   count_q;
  logic [lsdrs_pkg::ValueW-1:0] max_q;
  logic                         ovf_q;
  logic [lsdrs_pkg::PassW-1:0]  pass_q;
  logic [lsdrs_pkg::CntW-1:0]   run_q;

  // Read registers; they always hold the entry at the current index.
  logic [lsdrs_pkg::ValueW-1:0] rval_q, rquo_q, rsval_q, rsquo_q;

  logic [lsdrs_pkg::IdxW-1:0]   idx;
  logic [lsdrs_pkg::ValueW-1:0] cur_val, cur_quo, nxt_quo;
  logic [lsdrs_pkg::DigW-1:0]   dig;
  logic [lsdrs_pkg::DigW-1:0]   bin_idx;
  logic                         dig_ok;
  logic                         load_ok, val_we, sval_we;
  logic [lsdrs_pkg::IdxW-1:0]   val_wa, sval_wa;
  logic [lsdrs_pkg::ValueW-1:0] val_wd, quo_wd;

  assign idx     = idx_i;
  assign cur_val = rval_q;
  assign cur_quo = rquo_q;
  assign bin_idx = idx_i[lsdrs_pkg::DigW-1:0];
  assign dig_ok  = dig < lsdrs_pkg::DigW'(lsdrs_pkg::Radix);

  assign load_ok = cmd_i.load_store && (count_q < lsdrs_pkg::CntW'(lsdrs_pkg::MaxItems));
  assign val_we  = load_ok || cmd_i.copy_step;
  assign val_wa  = cmd_i.copy_step ? idx : count_q[lsdrs_pkg::IdxW-1:0];
  assign val_wd  = cmd_i.copy_step ? rsval_q : in_value_i;
  assign quo_wd  = cmd_i.copy_step ? rsquo_q : in_value_i;
  assign sval_we = cmd_i.scatter_step && dig_ok;
  assign sval_wa = bins_q[dig][lsdrs_pkg::IdxW-1:0];

  lsdrs_digit u_digit (
    .value_i (cur_quo),
    .quot_o  (nxt_quo),
    .digit_o (dig)
  );

  // Stores: loaded, scattered and copied one entry a cycle. The read address
  // runs one step ahead, and a write to that address at the same edge is
  // passed straight into the read register.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
      quo_mem[val_wa] <= quo_wd;
    end
    if (sval_we) begin
      sval_mem[sval_wa] <= cur_val;
      squo_mem[sval_wa] <= nxt_quo;
    end
    if (val_we && (val_wa == rd_idx_i)) begin
      rval_q <= val_wd;
      rquo_q <= quo_wd;
    end else begin
      rval_q <= val_mem[rd_idx_i];
      rquo_q <= quo_mem[rd_idx_i];
    end
    if (sval_we && (sval_wa == rd_idx_i)) begin
      rsval_q <= cur_val;
      rsquo_q <= nxt_quo;
    end else begin
      rsval_q <= sval_mem[rd_idx_i];
      rsquo_q <= squo_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < lsdrs_pkg::Radix; b++) bins_q[b] <= '0;
      count_q <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
      pass_q  <= '0;
      run_q   <= '0;
    end else begin
      if (cmd_i.load_store) begin
        if (count_q < lsdrs_pkg::CntW'(lsdrs_pkg::MaxItems)) begin
          count_q <= count_q + 1'b1;
          if (in_value_i > max_q) max_q <= in_value_i;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clear_bins) begin
        for (int b = 0; b < lsdrs_pkg::Radix; b++) bins_q[b] <= '0;
        run_q <= '0;
      end
      if (cmd_i.count_step && dig_ok) bins_q[dig] <= bins_q[dig] + 1'b1;
      if (cmd_i.prefix_step && (bin_idx < lsdrs_pkg::DigW'(lsdrs_pkg::Radix))) begin
        bins_q[bin_idx] <= run_q;
        run_q           <= run_q + bins_q[bin_idx];
      end
      if (cmd_i.scatter_step && dig_ok) bins_q[dig] <= bins_q[dig] + 1'b1;
      if (cmd_i.start_sort)   pass_q <= '0;
      if (cmd_i.next_divisor) pass_q <= pass_q + 1'b1;
      if (cmd_i.reset_run) begin
        count_q <= '0;
        max_q   <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  assign sts_o.count    = count_q;
  assign sts_o.passes   = lsdrs_pkg::digit_total(max_q);
  assign sts_o.pass_idx = pass_q;
  assign rd_value_o     = cur_val;
  assign overflow_o     = ovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lsdrs_pkg::CntW'(lsdrs_pkg::MaxItems))
    else $error("item count beyond capacity");
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q <= lsdrs_pkg::PassW'(10))
    else $error("pass counter beyond ten");
  a_reset_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reset_run |=> (count_q == '0) && !ovf_q)
    else $error("run state not cleared");
`endif
endmodule

[rtl/core/lsdrs_ctrl.sv]
module lsdrs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_last_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_end_o,
  input  lsdrs_pkg::dp_sts_t         sts_i,
  output lsdrs_pkg::dp_cmd_t         cmd_o,
  output logic [lsdrs_pkg::IdxW-1:0] idx_o,
  output logic [lsdrs_pkg::IdxW-1:0] rd_idx_o
);
  lsdrs_pkg::state_e state_q, state_d;
  logic [lsdrs_pkg::IdxW:0] idx_q, idx_d;
  logic in_acc, out_acc, idx_last, bin_last;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign idx_last = (idx_q + 1'b1) == (lsdrs_pkg::IdxW+1)'(sts_i.count);
  assign bin_last = idx_q == (lsdrs_pkg::IdxW+1)'(lsdrs_pkg::Radix - 1);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      lsdrs_pkg::StLoad: begin
        idx_d = '0;
        if (in_acc && in_last_i) begin
          if (sts_i.passes == '0) state_d = lsdrs_pkg::StEmit;
          else                    state_d = lsdrs_pkg::StCount;
        end
      end
      lsdrs_pkg::StCount: begin
        idx_d = idx_q + 1'b1;
        if (idx_last) begin
          idx_d = '0;
          state_d = lsdrs_pkg::StPrefix;
        end
      end
      lsdrs_pkg::StPrefix: begin
        idx_d = idx_q + 1'b1;
        if (bin_last) begin
          idx_d = '0;
          state_d = lsdrs_pkg::StScatter;
        end
      end
      lsdrs_pkg::StScatter: begin
        idx_d = idx_q + 1'b1;
        if (idx_last) begin
          idx_d = '0;
          state_d = lsdrs_pkg::StCopy;
        end
      end
      lsdrs_pkg::StCopy: begin
        idx_d = idx_q + 1'b1;
        if (idx_last) begin
          idx_d = '0;
          if (sts_i.pass_idx + 1'b1 == sts_i.passes) state_d = lsdrs_pkg::StEmit;
          else                                       state_d = lsdrs_pkg::StCount;
        end
      end
      lsdrs_pkg::StEmit: begin
        if (out_acc) begin
          idx_d = idx_q + 1'b1;
          if (idx_last) begin
            idx_d = '0;
            state_d = lsdrs_pkg::StLoad;
          end
        end
      end
      default: state_d = lsdrs_pkg::StLoad;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      lsdrs_pkg::StLoad: begin
        in_stall_o        = 1'b0;
        cmd_o.load_store  = in_valid_i;
        cmd_o.start_sort  = 1'b1;
        cmd_o.clear_bins  = 1'b1;
      end
      lsdrs_pkg::StCount:   cmd_o.count_step = 1'b1;
      lsdrs_pkg::StPrefix:  cmd_o.prefix_step = 1'b1;
      lsdrs_pkg::StScatter: cmd_o.scatter_step = 1'b1;
      lsdrs_pkg::StCopy: begin
        cmd_o.copy_step = 1'b1;
        if (idx_last) begin
          cmd_o.next_divisor = 1'b1;
          cmd_o.clear_bins   = 1'b1;
        end
      end
      lsdrs_pkg::StEmit: begin
        out_valid_o     = 1'b1;
        cmd_o.reset_run = !out_stall_i && idx_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsdrs_pkg::StLoad;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign out_end_o = idx_last;
  assign idx_o     = idx_q[lsdrs_pkg::IdxW-1:0];
  assign rd_idx_o  = idx_d[lsdrs_pkg::IdxW-1:0];

`ifndef SYNTHESIS
  a_no_out_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsdrs_pkg::StLoad) |-> !out_valid_o)
    else $error("result shown while loading");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsdrs_pkg::StEmit) |-> (sts_i.count != '0))
    else $error("emitting an empty run");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsdrs_pkg::StEmit) |-> (idx_q < (lsdrs_pkg::IdxW+1)'(sts_i.count)))
    else $error("emit index past run");
`endif
endmodule

[rtl/core/lsd_decimal_radix_sorter_core.sv]
// Channel   | valid      | stall       | payload
// input     | in_valid_i | in_stall_o  | item_value_i, item_is_last_i
// output    | out_valid_o| out_stall_i | sorted_value_o, run_end_o, overflowed_o
//
// Loading takes one beat a cycle. After the last beat the sorter runs one pass
// per decimal digit of the maximum: count N items, prefix ten bins, scatter
// N items, copy N back, one store entry per cycle. Results then leave one beat
// a cycle while out_stall_i is low. Reset clears all control state; the stores
// need none. Input stalls for the whole sort and emit phase.
module lsd_decimal_radix_sorter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lsdrs_pkg::ValueW-1:0] item_value_i,
  input  logic                         item_is_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lsdrs_pkg::ValueW-1:0] sorted_value_o,
  output logic                         run_end_o,
  output logic                         overflowed_o
);
  lsdrs_pkg::dp_cmd_t         cmd;
  lsdrs_pkg::dp_sts_t         sts;
  logic [lsdrs_pkg::IdxW-1:0] idx;
  logic [lsdrs_pkg::IdxW-1:0] rd_idx;

  // The controller holds the emit index, so a stalled result stays in place.
  // The next index goes to the datapath as the read address, so the
  // registered store reads already hold the entry at the current index.
  lsdrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (item_is_last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_end_o   (run_end_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .rd_idx_o    (rd_idx)
  );

  lsdrs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .rd_idx_i   (rd_idx),
    .in_value_i (item_value_i),
    .sts_o      (sts),
    .rd_value_o (sorted_value_o),
    .overflow_o (overflowed_o)
  );
endmodule
